### rtl/snappy_pkg.sv
// Shared types and constants for the raw Snappy decompressor.
// No dependencies; used by snappy_ctrl, snappy_dp and snappy_raw_decompressor.
package snappy_pkg;

  // History window size; must be a power of two.
  localparam int WINDOW_BYTES = 65536;
  localparam int HIST_AW = $clog2(WINDOW_BYTES);

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_TRUNC   = 3'd1;
  localparam logic [2:0] ST_BAD_OFF = 3'd2;
  localparam logic [2:0] ST_LEN     = 3'd3;
  localparam logic [2:0] ST_VARINT  = 3'd4;

  typedef enum logic [2:0] {
    PH_LEN     = 3'd0,
    PH_TAG     = 3'd1,
    PH_LITLEN  = 3'd2,
    PH_LITDATA = 3'd3,
    PH_OFF     = 3'd4,
    PH_DROP    = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_WR
  } ctrl_state_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_done;
    logic [2:0] status;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic rd;
    logic wr;
  } dp_cmd_t;

  typedef struct packed {
    logic copy_go;
    logic copy_end;
    logic out_free;
  } dp_stat_t;

endpackage

### rtl/snappy_ctrl.sv
// Controller for the Snappy decompressor: request acceptance and copy sequencing.
// Depends on snappy_pkg.
module snappy_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  snappy_pkg::dp_stat_t  stat,
  output snappy_pkg::dp_cmd_t   cmd
);

  snappy_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= snappy_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state_r)
      snappy_pkg::S_IDLE: begin
        in_ready   = stat.out_free;
        cmd.accept = in_valid && stat.out_free;
        if (cmd.accept && stat.copy_go) begin
          state_nxt = snappy_pkg::S_RD;
        end
      end
      snappy_pkg::S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = snappy_pkg::S_WR;
      end
      snappy_pkg::S_WR: begin
        if (stat.out_free) begin
          cmd.wr    = 1'b1;
          state_nxt = stat.copy_end ? snappy_pkg::S_IDLE : snappy_pkg::S_RD;
        end
      end
      default: begin
        state_nxt = snappy_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### rtl/snappy_dp.sv
// Datapath for the Snappy decompressor: stream parsing, history memory and
// output register. Depends on snappy_pkg; driven by snappy_ctrl.
module snappy_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  snappy_pkg::dp_cmd_t   cmd,
  output snappy_pkg::dp_stat_t  stat,
  input  snappy_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output snappy_pkg::out_item_t out_data
);

  localparam int AW = snappy_pkg::HIST_AW;

  logic [7:0] hist_mem [snappy_pkg::WINDOW_BYTES];
  logic [7:0] rdata_r;

  snappy_pkg::phase_t phase_r, phase_nxt;
  logic [31:0] prod_r, prod_nxt;
  logic [31:0] exp_r, exp_nxt;
  logic [5:0]  vshift_r, vshift_nxt;
  logic [32:0] lit_rem_r, lit_rem_nxt;
  logic [2:0]  extra_r, extra_nxt;
  logic [4:0]  ash_r, ash_nxt;
  logic [6:0]  clen_r, clen_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [2:0]  err_r, err_nxt;
  logic [6:0]  cnt_r;
  logic [AW-1:0] off_r;
  logic        last_r;
  logic        out_valid_r;
  snappy_pkg::out_item_t out_r;

  logic [7:0]  b;
  logic        emit;
  logic        go;
  logic [31:0] space;
  logic [31:0] acc_new;
  logic [32:0] lit_len;
  logic        lit_start;
  logic [5:0]  lf;
  logic [2:0]  st;
  logic        out_free;

  assign b        = in_data.in_byte;
  assign space    = exp_r - prod_r;
  assign acc_new  = acc_r | (32'(b) << ash_r);
  assign lf       = b[7:2];
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    phase_nxt   = phase_r;
    exp_nxt     = exp_r;
    vshift_nxt  = vshift_r;
    lit_rem_nxt = lit_rem_r;
    extra_nxt   = extra_r;
    ash_nxt     = ash_r;
    clen_nxt    = clen_r;
    acc_nxt     = acc_r;
    err_nxt     = err_r;
    emit        = 1'b0;
    go          = 1'b0;
    lit_start   = 1'b0;
    lit_len     = '0;
    case (phase_r)
      snappy_pkg::PH_LEN: begin
        if (vshift_r >= 6'd28 && b > 8'd15) begin
          err_nxt   = snappy_pkg::ST_VARINT;
          phase_nxt = snappy_pkg::PH_DROP;
        end else begin
          exp_nxt = exp_r | (32'(b[6:0]) << vshift_r[4:0]);
          if (!b[7]) begin
            phase_nxt = snappy_pkg::PH_TAG;
          end else begin
            vshift_nxt = vshift_r + 6'd7;
          end
        end
      end
      snappy_pkg::PH_TAG: begin
        ash_nxt = '0;
        acc_nxt = '0;
        if (b[1:0] == 2'd0) begin
          if (lf < 6'd60) begin
            lit_start = 1'b1;
            lit_len   = 33'(lf) + 33'd1;
          end else begin
            extra_nxt = 3'(lf - 6'd59);
            phase_nxt = snappy_pkg::PH_LITLEN;
          end
        end else if (b[1:0] == 2'd1) begin
          clen_nxt  = 7'(b[4:2]) + 7'd4;
          extra_nxt = 3'd1;
          acc_nxt   = {21'd0, b[7:5], 8'd0};
          phase_nxt = snappy_pkg::PH_OFF;
        end else begin
          clen_nxt  = 7'(lf) + 7'd1;
          extra_nxt = (b[1:0] == 2'd2) ? 3'd2 : 3'd4;
          phase_nxt = snappy_pkg::PH_OFF;
        end
      end
      snappy_pkg::PH_LITLEN, snappy_pkg::PH_OFF: begin
        acc_nxt   = acc_new;
        ash_nxt   = ash_r + 5'd8;
        extra_nxt = extra_r - 3'd1;
        if (extra_nxt == 3'd0) begin
          if (phase_r == snappy_pkg::PH_LITLEN) begin
            lit_start = 1'b1;
            lit_len   = {1'b0, acc_new} + 33'd1;
          end else if (acc_new == 32'd0 || acc_new > prod_r ||
                       acc_new > 32'(snappy_pkg::WINDOW_BYTES)) begin
            err_nxt   = snappy_pkg::ST_BAD_OFF;
            phase_nxt = snappy_pkg::PH_DROP;
          end else if (32'(clen_r) > space) begin
            err_nxt   = snappy_pkg::ST_LEN;
            phase_nxt = snappy_pkg::PH_DROP;
          end else begin
            go        = 1'b1;
            phase_nxt = snappy_pkg::PH_TAG;
          end
        end
      end
      snappy_pkg::PH_LITDATA: begin
        emit        = 1'b1;
        lit_rem_nxt = lit_rem_r - 33'd1;
        if (lit_rem_nxt == 33'd0) begin
          phase_nxt = snappy_pkg::PH_TAG;
        end
      end
      default: begin
      end
    endcase
    if (lit_start) begin
      if (lit_len > {1'b0, space}) begin
        err_nxt   = snappy_pkg::ST_LEN;
        phase_nxt = snappy_pkg::PH_DROP;
      end else begin
        lit_rem_nxt = lit_len;
        phase_nxt   = snappy_pkg::PH_LITDATA;
      end
    end
    prod_nxt = prod_r + 32'(emit);
  end

  // Closing status of a stream as it stands after this request.
  always_comb begin
    if (err_nxt != snappy_pkg::ST_OK) begin
      st = err_nxt;
    end else if (phase_nxt != snappy_pkg::PH_TAG) begin
      st = snappy_pkg::ST_TRUNC;
    end else if (prod_nxt != exp_nxt) begin
      st = snappy_pkg::ST_LEN;
    end else begin
      st = snappy_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= snappy_pkg::PH_LEN;
      prod_r      <= '0;
      exp_r       <= '0;
      vshift_r    <= '0;
      lit_rem_r   <= '0;
      extra_r     <= '0;
      ash_r       <= '0;
      clen_r      <= '0;
      acc_r       <= '0;
      err_r       <= '0;
      cnt_r       <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.accept) begin
        if (in_data.in_last && !go) begin
          phase_r   <= snappy_pkg::PH_LEN;
          prod_r    <= '0;
          exp_r     <= '0;
          vshift_r  <= '0;
          lit_rem_r <= '0;
          extra_r   <= '0;
          ash_r     <= '0;
          clen_r    <= '0;
          acc_r     <= '0;
          err_r     <= '0;
        end else begin
          phase_r   <= phase_nxt;
          prod_r    <= prod_nxt;
          exp_r     <= exp_nxt;
          vshift_r  <= vshift_nxt;
          lit_rem_r <= lit_rem_nxt;
          extra_r   <= extra_nxt;
          ash_r     <= ash_nxt;
          clen_r    <= clen_nxt;
          acc_r     <= acc_nxt;
          err_r     <= err_nxt;
        end
        if (go) begin
          cnt_r  <= clen_r;
          last_r <= in_data.in_last;
        end
        if (!go && (emit || in_data.in_last)) begin
          out_valid_r <= 1'b1;
        end
      end
      if (cmd.wr) begin
        cnt_r       <= cnt_r - 7'd1;
        out_valid_r <= 1'b1;
        if (cnt_r == 7'd1 && last_r) begin
          phase_r  <= snappy_pkg::PH_LEN;
          prod_r   <= '0;
          exp_r    <= '0;
          vshift_r <= '0;
          last_r   <= 1'b0;
        end else begin
          prod_r <= prod_r + 32'd1;
        end
      end
    end
  end

  // Payload registers: output item, copy offset, history read data and history memory.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      out_r.has_byte    <= emit;
      out_r.out_byte    <= emit ? b : 8'd0;
      out_r.run_last    <= 1'b1;
      out_r.stream_done <= in_data.in_last;
      out_r.status      <= in_data.in_last ? st : snappy_pkg::ST_OK;
      if (go) begin
        off_r <= acc_new[AW-1:0];
      end
      if (emit) begin
        hist_mem[prod_r[AW-1:0]] <= b;
      end
    end
    if (cmd.rd) begin
      rdata_r <= hist_mem[prod_r[AW-1:0] - off_r];
    end
    if (cmd.wr) begin
      hist_mem[prod_r[AW-1:0]] <= rdata_r;
      out_r.has_byte    <= 1'b1;
      out_r.out_byte    <= rdata_r;
      out_r.run_last    <= (cnt_r == 7'd1);
      out_r.stream_done <= (cnt_r == 7'd1) && last_r;
      out_r.status      <= ((cnt_r == 7'd1) && last_r && (prod_r + 32'd1 != exp_r)) ?
                           snappy_pkg::ST_LEN : snappy_pkg::ST_OK;
    end
  end

  assign stat.copy_go  = go;
  assign stat.copy_end = (cnt_r == 7'd1);
  assign stat.out_free = out_free;
  assign out_valid     = out_valid_r;
  assign out_data      = out_r;

  a_copy_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> prod_r != exp_r)
    else $error("copy byte beyond declared length");

  a_copy_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd || cmd.wr) |-> cnt_r != 7'd0)
    else $error("copy step with no bytes left");

  a_literal_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == snappy_pkg::PH_LITDATA |-> lit_rem_r != 33'd0)
    else $error("literal phase with nothing left");

  a_copy_close: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr && cnt_r == 7'd1 && last_r) |=> (phase_r == snappy_pkg::PH_LEN && prod_r == 32'd0))
    else $error("stream not cleared after final copy");

endmodule

### rtl/snappy_raw_decompressor.sv
// Top level of the raw Snappy decompressor.
// Depends on snappy_pkg, snappy_ctrl and snappy_dp.
//
//   channel | ports                         | moves
//   in      | in_valid, in_ready, in_data   | one compressed byte and its last mark
//   out     | out_valid, out_ready, out_data| one decompressed byte and/or status
//
// A preamble, tag, length or literal byte is taken as one request. A copy is
// taken with its last offset byte; each copied byte then passes S_RD (history
// read) and S_WR (write and output), which waits on a stalled output register.
// The single history memory port pair sets the copy rate.
// rst_n is synchronous; the history memory is not cleared.
// A stalled output register holds input back until the pending request leaves.
module snappy_raw_decompressor (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  snappy_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output snappy_pkg::out_item_t out_data
);

  snappy_pkg::dp_cmd_t  cmd;
  snappy_pkg::dp_stat_t stat;

  snappy_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  snappy_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
